// ===== rtl/core/ufd_pkg.sv =====
// Shared types and sizing constants for the UTF-8 stream decoder.
`default_nettype none
package ufd_pkg;

   localparam int ByteWidth   = 8;
   localparam int TrailWidth  = 3;
   localparam int CodeWidth   = 32;
   localparam int LengthWidth = 3;

   localparam int DefaultQueueDepth  = 4;
   localparam int DefaultResultDepth = 2;

   // One classified input byte as it travels from the front to the back.
   typedef struct packed {
      logic [ByteWidth-1:0]  data;
      logic                  zero;
      logic [TrailWidth-1:0] trail;
   } ufd_item_type;

   // One decoded character.
   typedef struct packed {
      logic [CodeWidth-1:0]   code_point;
      logic [LengthWidth-1:0] seq_length;
   } ufd_result_type;

endpackage
`default_nettype wire

// ===== rtl/core/ufd_fifo.sv =====
// Small flip-flop queue with a combinational head read.
`default_nettype none
module ufd_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   logic [Width-1:0]    store_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CntWidth'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == PtrWidth'(Depth - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + PtrWidth'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == PtrWidth'(Depth - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + PtrWidth'(1);
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ufd_front.sv =====
// Front end: classifies each incoming byte by the trailing count its lead value announces.
`default_nettype none
module ufd_front (
   input  logic [ufd_pkg::ByteWidth-1:0] in_byte,
   output ufd_pkg::ufd_item_type         item
);

   logic [ufd_pkg::TrailWidth-1:0] trail;

   always_comb begin
      if (in_byte < 8'hC0) begin
         trail = 3'd0;
      end else if (in_byte < 8'hE0) begin
         trail = 3'd1;
      end else if (in_byte < 8'hF0) begin
         trail = 3'd2;
      end else if (in_byte < 8'hF8) begin
         trail = 3'd3;
      end else if (in_byte < 8'hFC) begin
         trail = 3'd4;
      end else begin
         trail = 3'd5;
      end
   end

   assign item.data  = in_byte;
   assign item.zero  = (in_byte == '0);
   assign item.trail = trail;

endmodule
`default_nettype wire

// ===== rtl/core/ufd_back.sv =====
// Back end: accumulates sequence bytes and produces one decoded character per sequence.
`default_nettype none
module ufd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ufd_pkg::ufd_item_type  item,
   input  logic                   item_valid,
   output logic                   item_take,
   input  logic                   result_full,
   output logic                   result_push,
   output ufd_pkg::ufd_result_type result
);

   logic [ufd_pkg::TrailWidth-1:0] trail_total_ff, trail_total_in;
   logic [ufd_pkg::TrailWidth-1:0] bytes_taken_ff, bytes_taken_in;
   logic [ufd_pkg::CodeWidth-1:0]  accum_ff, accum_in;

   logic [ufd_pkg::TrailWidth-1:0] total;
   logic [ufd_pkg::TrailWidth-1:0] remaining;
   logic [4:0]                     shift_amount;
   logic [ufd_pkg::CodeWidth-1:0]  base;
   logic [ufd_pkg::CodeWidth-1:0]  sum;
   logic [ufd_pkg::CodeWidth-1:0]  offset;
   logic                           last;

   assign item_take = item_valid && !result_full;

   always_comb begin
      if (bytes_taken_ff == '0) begin
         total = item.trail;
         base  = '0;
      end else begin
         total = trail_total_ff;
         base  = accum_ff;
      end
      remaining = total - bytes_taken_ff;
      case (remaining)
         3'd0:    shift_amount = 5'd0;
         3'd1:    shift_amount = 5'd6;
         3'd2:    shift_amount = 5'd12;
         3'd3:    shift_amount = 5'd18;
         3'd4:    shift_amount = 5'd24;
         default: shift_amount = 5'd30;
      endcase
      sum  = base + (ufd_pkg::CodeWidth'(item.data) << shift_amount);
      last = (bytes_taken_ff >= total);
      // The offset strips the marker bits of the lead and continuation bytes.
      case (total)
         3'd0:    offset = 32'h0000_0000;
         3'd1:    offset = 32'h0000_3080;
         3'd2:    offset = 32'h000E_2080;
         3'd3:    offset = 32'h03C8_2080;
         3'd4:    offset = 32'hFA08_2080;
         default: offset = 32'h8208_2080;
      endcase
   end

   always_comb begin
      trail_total_in    = trail_total_ff;
      bytes_taken_in    = bytes_taken_ff;
      accum_in          = accum_ff;
      result_push       = 1'b0;
      result.code_point = sum - offset;
      result.seq_length = total + ufd_pkg::LengthWidth'(1);
      if (item_take) begin
         if (item.zero) begin
            result_push       = 1'b1;
            result.code_point = '0;
            result.seq_length = '0;
            trail_total_in    = '0;
            bytes_taken_in    = '0;
            accum_in          = '0;
         end else if (last) begin
            result_push    = 1'b1;
            trail_total_in = '0;
            bytes_taken_in = '0;
            accum_in       = '0;
         end else begin
            trail_total_in = total;
            bytes_taken_in = bytes_taken_ff + ufd_pkg::TrailWidth'(1);
            accum_in       = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trail_total_ff <= '0;
         bytes_taken_ff <= '0;
         accum_ff       <= '0;
      end else begin
         trail_total_ff <= trail_total_in;
         bytes_taken_ff <= bytes_taken_in;
         accum_ff       <= accum_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level of the UTF-8 to UTF-32 stream decoder.
// The decoder takes one byte per beat and sustains one byte per clock cycle while req_full
// is low. A byte is classified on entry and written into a queue of QueueDepth entries; the
// sequence accumulator drains that queue at one byte per cycle unless the result queue is
// full, and writes each finished character into a result queue of ResultDepth entries. A
// character's last byte is registered in the input queue and the character in the result
// queue before it reaches the result ports. A zero byte yields code point 0 with length 0
// and drops any partial sequence; an incomplete sequence yields nothing until it completes.
`default_nettype none
module utf8_stream_decoder #(
   parameter int QueueDepth  = ufd_pkg::DefaultQueueDepth,
   parameter int ResultDepth = ufd_pkg::DefaultResultDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [ufd_pkg::ByteWidth-1:0]   req_in_byte,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [ufd_pkg::CodeWidth-1:0]   rsp_code_point,
   output logic [ufd_pkg::LengthWidth-1:0] rsp_seq_length
);

   ufd_pkg::ufd_item_type   front_item;
   ufd_pkg::ufd_item_type   head_item;
   ufd_pkg::ufd_result_type back_result;
   ufd_pkg::ufd_result_type out_result;
   logic                    queue_empty;
   logic                    item_take;
   logic                    result_full;
   logic                    result_push;

   ufd_front u_front (
      .in_byte (req_in_byte),
      .item    (front_item)
   );

   ufd_fifo #(
      .Width ($bits(ufd_pkg::ufd_item_type)),
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (item_take),
      .pop_data  (head_item),
      .empty     (queue_empty)
   );

   ufd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item        (head_item),
      .item_valid  (!queue_empty),
      .item_take   (item_take),
      .result_full (result_full),
      .result_push (result_push),
      .result      (back_result)
   );

   ufd_fifo #(
      .Width ($bits(ufd_pkg::ufd_result_type)),
      .Depth (ResultDepth)
   ) u_results (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (out_result),
      .empty     (rsp_empty)
   );

   assign rsp_code_point = out_result.code_point;
   assign rsp_seq_length = out_result.seq_length;

endmodule
`default_nettype wire
